### src/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and constants for the truth-table store with Walsh transform.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int TABLE_W  = 64;
  localparam int HANDLE_W = 10;
  localparam int COEF_W   = 8;
  localparam int CMD_W    = 2;
  localparam int ERR_W    = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_NOT   = 2'd0,
    CMD_AND   = 2'd1,
    CMD_XOR   = 2'd2,
    CMD_XFORM = 2'd3
  } cmd_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_UNDEF = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    RD_A,
    RD_B,
    RD_IDX
  } rd_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_FETCH_A,
    S_FETCH_B,
    S_BUILD,
    S_SEARCH,
    S_XFORM,
    S_OUT
  } state_t;

  typedef struct packed {
    logic    capture;
    rd_sel_t rd_sel;
    logic    latch_a;
    logic    latch_b;
    logic    build;
    logic    search;
    logic    load_hit;
    logic    load_full;
    logic    append;
    logic    load_bad;
    logic    pass;
    logic    first_coef;
    logic    next_coef;
  } ctrl_t;

  typedef struct packed {
    logic bad;
    logic is_xform;
    logic hit;
    logic miss;
    logic full;
    logic pass_done;
    logic out_last;
  } status_t;

endpackage

### src/tts_ram.sv
// ----------------------------------------------------------------------------
// tts_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tts_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/tts_ctrl.sv
// ----------------------------------------------------------------------------
// tts_ctrl
// Sequencer: operand check, fetch, search or transform passes, result beats.
// ----------------------------------------------------------------------------
module tts_ctrl import tts_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output ctrl_t   ctrl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (in_valid) state_next = S_CHECK;
      S_CHECK:   state_next = status.bad ? S_OUT : S_FETCH_A;
      S_FETCH_A: state_next = S_FETCH_B;
      S_FETCH_B: state_next = S_BUILD;
      S_BUILD:   state_next = status.is_xform ? S_XFORM : S_SEARCH;
      S_SEARCH:  if (status.hit || status.miss) state_next = S_OUT;
      S_XFORM:   if (status.pass_done) state_next = S_OUT;
      S_OUT:     if (out_ready && status.out_last) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl      = '0;
    ctrl.rd_sel = RD_IDX;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready     = 1'b1;
        ctrl.capture = in_valid;
      end
      S_CHECK: begin
        ctrl.rd_sel   = RD_A;
        ctrl.load_bad = status.bad;
      end
      S_FETCH_A: begin
        ctrl.rd_sel  = RD_B;
        ctrl.latch_a = 1'b1;
      end
      S_FETCH_B: ctrl.latch_b = 1'b1;
      S_BUILD:   ctrl.build = 1'b1;
      S_SEARCH: begin
        ctrl.search = 1'b1;
        if (status.hit) begin
          ctrl.load_hit = 1'b1;
        end else if (status.miss) begin
          ctrl.load_full = status.full;
          ctrl.append    = !status.full;
        end
      end
      S_XFORM: begin
        if (status.pass_done) ctrl.first_coef = 1'b1;
        else ctrl.pass = 1'b1;
      end
      S_OUT: begin
        out_valid      = 1'b1;
        ctrl.next_coef = out_ready && !status.out_last;
      end
      default: ;
    endcase
  end

endmodule

### src/tts_dp.sv
// ----------------------------------------------------------------------------
// tts_dp
// Datapath: store RAM, entry count, search pointer, Walsh lanes, result regs.
// ----------------------------------------------------------------------------
module tts_dp import tts_pkg::*; #(
  parameter int NUM_INPUTS    = 6,
  parameter int STORE_ENTRIES = 1024,
  parameter int NUM_COEFFS    = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ctrl_t                    ctrl,
  output status_t                  status,
  input  logic [CMD_W-1:0]         command,
  input  logic [HANDLE_W-1:0]      operand_a,
  input  logic [HANDLE_W-1:0]      operand_b,
  output logic [HANDLE_W-1:0]      handle,
  output logic signed [COEF_W-1:0] coefficient,
  output logic                     last,
  output logic [ERR_W-1:0]         error
);

  localparam int AW    = $clog2(STORE_ENTRIES);
  localparam int CW    = AW + 1;
  localparam int XW    = (CW > HANDLE_W) ? CW : HANDLE_W;
  localparam int BASE  = NUM_INPUTS + 2;
  localparam int TBITS = 2 ** NUM_INPUTS;
  localparam int HALF  = TBITS / 2;
  localparam int NEFF  = (NUM_COEFFS < TBITS) ? NUM_COEFFS : TBITS;
  localparam logic [TABLE_W-1:0] MASK =
    (NUM_INPUTS == 6) ? '1 : ((64'd1 << TBITS) - 64'd1);

  cmd_t                 cmd_q;
  logic [HANDLE_W-1:0]  a_q, b_q;
  logic [CW-1:0]        count;
  logic [CW-1:0]        idx;
  logic                 cmp_v;
  logic [AW-1:0]        rd_q;
  logic [AW-1:0]        raddr;
  logic [TABLE_W-1:0]   rdata, word, word_a, word_b, cand;
  logic [2:0]           pass_cnt;
  logic [6:0]           coef_cnt;
  logic signed [COEF_W-1:0] lanes [TBITS];
  logic signed [COEF_W-1:0] lanes_next [TBITS];

  // constants and projections live in logic, not in the RAM
  function automatic logic [TABLE_W-1:0] base_word(input logic [AW-1:0] k);
    logic [TABLE_W-1:0] w;
    logic [AW-1:0]      j;
    j = k - AW'(2);
    for (int i = 0; i < TABLE_W; i++) begin
      w[i] = (k == '0) ? 1'b0 : (k == AW'(1)) ? 1'b1 : i[j[2:0]];
    end
    return w & MASK;
  endfunction

  always_comb begin
    unique case (ctrl.rd_sel)
      RD_A:    raddr = AW'(a_q);
      RD_B:    raddr = AW'(b_q);
      default: raddr = idx[AW-1:0];
    endcase
  end

  tts_ram #(.WIDTH(TABLE_W), .DEPTH(STORE_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ctrl.append),
    .waddr (count[AW-1:0]),
    .wdata (cand),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign word = (rd_q < AW'(BASE)) ? base_word(rd_q) : rdata;

  always_comb begin
    status.bad = (XW'(a_q) >= XW'(count)) ||
                 ((cmd_q == CMD_AND || cmd_q == CMD_XOR) && (XW'(b_q) >= XW'(count)));
    status.is_xform  = (cmd_q == CMD_XFORM);
    status.hit       = cmp_v && (word == cand);
    status.miss      = !cmp_v && (idx == count);
    status.full      = (count >= CW'(STORE_ENTRIES));
    status.pass_done = (pass_cnt == 3'(NUM_INPUTS));
    status.out_last  = last;
  end

  always_comb begin
    for (int i = 0; i < TBITS; i++) lanes_next[i] = lanes[i];
    if (ctrl.build) begin
      for (int i = 0; i < TBITS; i++) lanes_next[i] = word_a[i] ? -8'sd1 : 8'sd1;
    end else if (ctrl.pass) begin
      // constant-geometry butterfly: pairs feed the low and high halves
      for (int k = 0; k < HALF; k++) begin
        lanes_next[k]        = lanes[2*k] + lanes[2*k+1];
        lanes_next[k + HALF] = lanes[2*k] - lanes[2*k+1];
      end
    end else if (ctrl.first_coef || ctrl.next_coef) begin
      for (int i = 0; i < TBITS - 1; i++) lanes_next[i] = lanes[i+1];
      lanes_next[TBITS-1] = '0;
    end
  end

  always_ff @(posedge clk) begin
    rd_q <= raddr;
    for (int i = 0; i < TBITS; i++) lanes[i] <= lanes_next[i];
    if (ctrl.capture) begin
      cmd_q <= cmd_t'(command);
      a_q   <= operand_a;
      b_q   <= operand_b;
    end
    if (ctrl.latch_a) word_a <= word;
    if (ctrl.latch_b) word_b <= word;
    if (ctrl.build) begin
      unique case (cmd_q)
        CMD_NOT: cand <= ~word_a & MASK;
        CMD_AND: cand <= word_a & word_b;
        default: cand <= word_a ^ word_b;
      endcase
      pass_cnt <= '0;
    end else if (ctrl.pass) begin
      pass_cnt <= pass_cnt + 3'd1;
    end
    if (ctrl.load_hit) begin
      handle <= HANDLE_W'(rd_q);
      error  <= ERR_OK;
    end
    if (ctrl.append) begin
      handle <= HANDLE_W'(count);
      error  <= ERR_OK;
    end
    if (ctrl.load_full || ctrl.load_bad) begin
      handle <= '0;
      error  <= ctrl.load_full ? ERR_FULL : ERR_UNDEF;
    end
    if (ctrl.load_hit || ctrl.append || ctrl.load_full || ctrl.load_bad) begin
      coefficient <= '0;
      last        <= 1'b1;
    end
    if (ctrl.first_coef || ctrl.next_coef) begin
      handle      <= '0;
      error       <= ERR_OK;
      coefficient <= lanes[0];
      coef_cnt    <= ctrl.first_coef ? 7'd1 : coef_cnt + 7'd1;
      last        <= ctrl.first_coef ? (NEFF == 1) : (coef_cnt + 7'd1 == 7'(NEFF));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= CW'(BASE);
      idx   <= '0;
      cmp_v <= 1'b0;
    end else begin
      if (ctrl.append) count <= count + CW'(1);
      if (ctrl.build) begin
        idx   <= '0;
        cmp_v <= 1'b0;
      end else if (ctrl.search) begin
        // issue one read a cycle; compare lags by the RAM latency
        cmp_v <= (idx < count);
        if (idx < count) idx <= idx + CW'(1);
      end
    end
  end

endmodule

### src/truth_table_store_walsh_transform.sv
// ----------------------------------------------------------------------------
// truth_table_store_walsh_transform
// Top level: handle-addressed truth-table store with Walsh-Hadamard output.
// ----------------------------------------------------------------------------
// One command is taken at a time. NOT, AND and XOR run a deduplication search
// over all used store entries (count of them), reading one entry a cycle
// through the single read port of the store RAM. TRANSFORM runs the fetch and
// the butterfly passes (one pass of all lanes a cycle), then one result beat
// per coefficient. Handles below NUM_INPUTS + 2 are built in logic, so no
// clearing pass follows reset.
module truth_table_store_walsh_transform import tts_pkg::*; #(
  parameter int NUM_INPUTS    = 6,
  parameter int STORE_ENTRIES = 1024,
  parameter int NUM_COEFFS    = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [CMD_W-1:0]         command,
  input  logic [HANDLE_W-1:0]      operand_a,
  input  logic [HANDLE_W-1:0]      operand_b,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [HANDLE_W-1:0]      handle,
  output logic signed [COEF_W-1:0] coefficient,
  output logic                     last,
  output logic [ERR_W-1:0]         error
);

  ctrl_t   ctrl;
  status_t status;

  tts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .ctrl      (ctrl)
  );

  tts_dp #(
    .NUM_INPUTS    (NUM_INPUTS),
    .STORE_ENTRIES (STORE_ENTRIES),
    .NUM_COEFFS    (NUM_COEFFS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .status      (status),
    .command     (command),
    .operand_a   (operand_a),
    .operand_b   (operand_b),
    .handle      (handle),
    .coefficient (coefficient),
    .last        (last),
    .error       (error)
  );

endmodule
